/* sv/adaptive_packet_jitter_buffer_macros.svh */
// assertion macros for the adaptive packet jitter buffer
// included by the rtl files that carry concurrent assertions, no other dependencies
`ifndef ADAPTIVE_PACKET_JITTER_BUFFER_MACROS_SVH
`define ADAPTIVE_PACKET_JITTER_BUFFER_MACROS_SVH

// condition holds at every clock edge outside reset
`define APJB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define APJB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define APJB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/apjb_pkg.sv */
// shared types and constants of the adaptive packet jitter buffer
// no dependencies
package apjb_pkg;

  localparam int SEQ_W        = 16;
  localparam int HANDLE_W     = 32;
  localparam int JITTER_W     = 10;
  localparam int THR_W        = 7;
  localparam int OCC_W        = 7;
  localparam int PPA_W        = 10;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 10;

  // transaction kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_THRESHOLD     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_THRESHOLD     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ADAPTIVE_ENABLE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_POPS_PER_ADAPT    = 3'd4;

  // configuration reset values
  localparam logic [THR_W-1:0] RST_INITIAL_THRESHOLD = 7'd3;
  localparam logic [THR_W-1:0] RST_MIN_THRESHOLD     = 7'd2;
  localparam logic [THR_W-1:0] RST_MAX_THRESHOLD     = 7'd20;
  localparam logic             RST_ADAPTIVE_ENABLE   = 1'b1;
  localparam logic [PPA_W-1:0] RST_POPS_PER_ADAPT    = 10'd50;

  // playout policy constants
  localparam logic [7:0]       PILEUP_MARGIN = 8'd3;
  localparam logic [SEQ_W-1:0] BURST_GAP     = 16'd5;
  localparam logic [8:0]       BASE_FRAMES   = 9'd2;
  localparam logic [10:0]      JITTER_ROUND  = 11'd4;
  // x / 5 == (x * 3277) >> 14 for every x up to 1027
  localparam logic [11:0]      JITTER_RECIP  = 12'd3277;
  localparam int               JITTER_SHIFT  = 14;

  typedef struct packed {
    logic                kind;
    logic [SEQ_W-1:0]    sequence_req;
    logic [HANDLE_W-1:0] payload;
    logic [JITTER_W-1:0] jitter_est;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic [SEQ_W-1:0]    out_sequence;
    logic [HANDLE_W-1:0] out_payload;
    logic [THR_W-1:0]    threshold_now;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0] initial_threshold;
    logic [THR_W-1:0] min_threshold;
    logic [THR_W-1:0] max_threshold;
    logic             adaptive_enable;
    logic [PPA_W-1:0] pops_per_adapt;
  } cfg_t;

  // outcome of one sweep over the slot memory
  typedef struct packed {
    logic             hit;
    logic             low;
    logic             free;
    logic [SEQ_W-1:0] low_seq;
  } scan_status_t;

  // a is older than b in 16-bit serial number order
  function automatic logic serially_older(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

endpackage

/* sv/apjb_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module apjb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/apjb_scan.sv */
// sweep engine: reads every slot once and finds the key match, the lowest key and a free slot
// depends on apjb_pkg
module apjb_scan #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [apjb_pkg::SEQ_W-1:0]        key,
  input  logic [CAPACITY-1:0]               slot_valid,
  input  logic [apjb_pkg::SEQ_W+PAYLOAD_BITS-1:0] rd_data,
  output logic                              rd_en,
  output logic [$clog2(CAPACITY)-1:0]       rd_addr,
  output logic                              done,
  output apjb_pkg::scan_status_t            status,
  output logic [$clog2(CAPACITY)-1:0]       hit_idx,
  output logic [PAYLOAD_BITS-1:0]           hit_pay,
  output logic [$clog2(CAPACITY)-1:0]       low_idx,
  output logic [PAYLOAD_BITS-1:0]           low_pay,
  output logic [$clog2(CAPACITY)-1:0]       free_idx
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int ENTRY_W = apjb_pkg::SEQ_W + PAYLOAD_BITS;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

  logic                       busy;
  logic [IDX_W-1:0]           addr;
  logic [apjb_pkg::SEQ_W-1:0] key_q;
  logic                       pend;
  logic [IDX_W-1:0]           pend_idx;
  logic                       pend_vld;
  logic [apjb_pkg::SEQ_W-1:0] entry_seq;
  logic [PAYLOAD_BITS-1:0]    entry_pay;

  assign rd_en     = busy;
  assign rd_addr   = addr;
  assign entry_seq = rd_data[ENTRY_W-1 -: apjb_pkg::SEQ_W];
  assign entry_pay = rd_data[PAYLOAD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pend        <= 1'b0;
      done        <= 1'b0;
      status.hit  <= 1'b0;
      status.low  <= 1'b0;
      status.free <= 1'b0;
    end else begin
      done     <= pend && (pend_idx == LAST);
      pend     <= busy;
      pend_idx <= addr;
      pend_vld <= slot_valid[addr];
      if (start) begin
        busy        <= 1'b1;
        addr        <= '0;
        key_q       <= key;
        status.hit  <= 1'b0;
        status.low  <= 1'b0;
        status.free <= 1'b0;
      end else begin
        if (busy) begin
          if (addr == LAST) begin
            busy <= 1'b0;
          end else begin
            addr <= addr + IDX_W'(1);
          end
        end
        // read data of the previous address is here now
        if (pend) begin
          if (pend_vld) begin
            if (!status.hit && (entry_seq == key_q)) begin
              status.hit <= 1'b1;
              hit_idx    <= pend_idx;
              hit_pay    <= entry_pay;
            end
            if (!status.low || (entry_seq < status.low_seq)) begin
              status.low     <= 1'b1;
              status.low_seq <= entry_seq;
              low_idx        <= pend_idx;
              low_pay        <= entry_pay;
            end
          end else if (!status.free) begin
            status.free <= 1'b1;
            free_idx    <= pend_idx;
          end
        end
      end
    end
  end

endmodule

/* sv/apjb_adapt.sv */
// adaptive target threshold: clamp(2 + ceil(jitter / 5), min, max), two register stages
// depends on apjb_pkg
module apjb_adapt (
  input  logic                          clk,
  input  logic [apjb_pkg::JITTER_W-1:0] jitter,
  input  apjb_pkg::cfg_t                cfg,
  output logic [apjb_pkg::THR_W-1:0]    target
);

  logic [10:0] jitter_up;
  logic [22:0] prod;
  logic [8:0]  raw;
  logic [8:0]  capped;
  logic [8:0]  clamped;

  // ceil(j / 5) as floor((j + 4) / 5) by reciprocal multiply
  assign jitter_up = {1'b0, jitter} + apjb_pkg::JITTER_ROUND;

  always_ff @(posedge clk) begin
    prod <= 23'(jitter_up * apjb_pkg::JITTER_RECIP);
  end

  always_comb begin
    raw     = 9'(prod >> apjb_pkg::JITTER_SHIFT) + apjb_pkg::BASE_FRAMES;
    capped  = (raw > 9'(cfg.max_threshold)) ? 9'(cfg.max_threshold) : raw;
    // min wins when the clamps cross
    clamped = (capped < 9'(cfg.min_threshold)) ? 9'(cfg.min_threshold) : capped;
  end

  always_ff @(posedge clk) begin
    target <= apjb_pkg::THR_W'(clamped);
  end

endmodule

/* sv/adaptive_packet_jitter_buffer.sv */
// top level of the adaptive packet jitter buffer: control, playout state and output register
// depends on apjb_pkg, apjb_ram, apjb_scan, apjb_adapt and the assertion macro header
// Keyed packet store with adaptive playout threshold. Each transaction on req is a push
// (store a 16-bit sequence with a payload handle) or a pop (deliver the next packet in
// sequence order), and each yields exactly one result on rsp. Packets live in one
// synchronous ram of CAPACITY entries; valid bits sit in flip-flops, so reset empties the
// store at once and no clearing pass runs. Every transaction sweeps the whole ram once
// through its single read port, so no new request is taken during the sweep, and a
// finished result also waits while rsp_stall holds the output register. The input is
// taken again as soon as the previous transaction has been written into the output
// register; a result may still wait on rsp meanwhile. Pushes older than the playout
// point, or into a full store, are refused; duplicates report ok without being stored.
// Playout starts at the lowest stored key once the threshold is met; a missing head is
// skipped on pile-up or burst loss. Configuration must be written through
// cfg_we/cfg_index/cfg_data only while no transaction is in flight, which is not enforced.
`include "adaptive_packet_jitter_buffer_macros.svh"

module adaptive_packet_jitter_buffer #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  apjb_pkg::in_item_t                  req,
  // result channel
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output apjb_pkg::out_item_t                 rsp,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [apjb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [apjb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > 8) ? CNT_W : 8;
  localparam int ENTRY_W = apjb_pkg::SEQ_W + PAYLOAD_BITS;

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;

  // configuration and playout state
  apjb_pkg::cfg_t               cfg;
  logic [apjb_pkg::THR_W-1:0]   live_threshold;
  logic [apjb_pkg::THR_W-1:0]   live_threshold_next;
  logic                         playing;
  logic [apjb_pkg::SEQ_W-1:0]   expected_sequence;
  logic [apjb_pkg::PPA_W-1:0]   pops_since_step;
  logic [apjb_pkg::PPA_W-1:0]   pops_since_step_next;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic [CAPACITY-1:0]          slot_valid;

  // transaction held while it is being worked on
  logic                          kind_q;
  logic [apjb_pkg::SEQ_W-1:0]    seq_q;
  logic [PAYLOAD_BITS-1:0]       pay_q;
  logic [apjb_pkg::JITTER_W-1:0] jitter_q;

  // memory and sweep engine
  logic                          ram_we;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [ENTRY_W-1:0]            ram_rdata;
  logic                          scan_start;
  logic [apjb_pkg::SEQ_W-1:0]    scan_key;
  logic                          scan_done;
  apjb_pkg::scan_status_t        scan_st;
  logic [IDX_W-1:0]              hit_idx;
  logic [PAYLOAD_BITS-1:0]       hit_pay;
  logic [IDX_W-1:0]              low_idx;
  logic [PAYLOAD_BITS-1:0]       low_pay;
  logic [IDX_W-1:0]              free_idx;
  logic [apjb_pkg::THR_W-1:0]    target;

  // decision terms of the finishing cycle
  logic                          finish;
  logic                          push_old;
  logic                          push_full;
  logic                          push_ok;
  logic                          push_store;
  logic                          pile;
  logic                          burst;
  logic                          start_ok;
  logic                          take_hit;
  logic                          take_low;
  logic                          pop_ok;
  logic [IDX_W-1:0]              pop_idx;
  logic [apjb_pkg::SEQ_W-1:0]    pop_seq;
  logic [PAYLOAD_BITS-1:0]       pop_pay;
  logic [apjb_pkg::PPA_W-1:0]    pops_inc;
  logic                          step_due;

  // one transaction at a time; the sweep and the final write never overlap
  assign req_stall  = (state != ST_IDLE);
  assign scan_start = req_valid && !req_stall;
  // a pop looks for the expected sequence, a push for a duplicate
  assign scan_key   = (req.kind == apjb_pkg::KIND_POP) ? expected_sequence : req.sequence_req;
  // finish only once the output register can take the result
  assign finish     = (state == ST_FINISH) && (!rsp_valid || !rsp_stall);

  apjb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata ({seq_q, pay_q}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  apjb_scan #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (scan_start),
    .key        (scan_key),
    .slot_valid (slot_valid),
    .rd_data    (ram_rdata),
    .rd_en      (ram_re),
    .rd_addr    (ram_raddr),
    .done       (scan_done),
    .status     (scan_st),
    .hit_idx    (hit_idx),
    .hit_pay    (hit_pay),
    .low_idx    (low_idx),
    .low_pay    (low_pay),
    .free_idx   (free_idx)
  );

  apjb_adapt u_adapt (
    .clk    (clk),
    .jitter (jitter_q),
    .cfg    (cfg),
    .target (target)
  );

  always_comb begin
    // push checks
    push_old   = playing && apjb_pkg::serially_older(seq_q, expected_sequence);
    push_full  = CMP_W'(count) >= CMP_W'(CAPACITY);
    push_ok    = !push_old && !push_full;
    push_store = (kind_q == apjb_pkg::KIND_PUSH) && push_ok && !scan_st.hit;
    ram_we     = finish && push_store;

    // head skip on pile-up or burst loss
    pile  = CMP_W'(count) >= (CMP_W'(live_threshold) + CMP_W'(apjb_pkg::PILEUP_MARGIN));
    burst = scan_st.low &&
            apjb_pkg::serially_older(expected_sequence + apjb_pkg::BURST_GAP, scan_st.low_seq);

    // start of playout takes the lowest key once the threshold is met
    start_ok = scan_st.low && !(CMP_W'(count) < CMP_W'(live_threshold));
    take_hit = playing && scan_st.hit;
    take_low = playing ? (!scan_st.hit && scan_st.low && (pile || burst)) : start_ok;
    pop_ok   = (kind_q == apjb_pkg::KIND_POP) && (take_hit || take_low);
    pop_idx  = take_hit ? hit_idx : low_idx;
    pop_seq  = take_hit ? expected_sequence : scan_st.low_seq;
    pop_pay  = take_hit ? hit_pay : low_pay;

    // threshold adaptation after a delivered packet
    pops_inc             = pops_since_step + apjb_pkg::PPA_W'(1);
    step_due             = pops_inc >= cfg.pops_per_adapt;
    live_threshold_next  = live_threshold;
    pops_since_step_next = pops_since_step;
    if (pop_ok && cfg.adaptive_enable) begin
      if (step_due) begin
        pops_since_step_next = '0;
        if (target > live_threshold) begin
          live_threshold_next = live_threshold + apjb_pkg::THR_W'(1);
        end else if (target < live_threshold) begin
          live_threshold_next = live_threshold - apjb_pkg::THR_W'(1);
        end
      end else begin
        pops_since_step_next = pops_inc;
      end
    end

    count_next = count + CNT_W'(push_store) - CNT_W'(pop_ok);
  end

  // control and playout state
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= ST_IDLE;
      cfg.initial_threshold <= apjb_pkg::RST_INITIAL_THRESHOLD;
      cfg.min_threshold     <= apjb_pkg::RST_MIN_THRESHOLD;
      cfg.max_threshold     <= apjb_pkg::RST_MAX_THRESHOLD;
      cfg.adaptive_enable   <= apjb_pkg::RST_ADAPTIVE_ENABLE;
      cfg.pops_per_adapt    <= apjb_pkg::RST_POPS_PER_ADAPT;
      live_threshold        <= apjb_pkg::RST_INITIAL_THRESHOLD;
      playing               <= 1'b0;
      expected_sequence     <= '0;
      pops_since_step       <= '0;
      count                 <= '0;
      slot_valid            <= '0;
      rsp_valid             <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (scan_start) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (finish) begin
        count           <= count_next;
        live_threshold  <= live_threshold_next;
        pops_since_step <= pops_since_step_next;
        if (push_store) begin
          slot_valid[free_idx] <= 1'b1;
        end
        if (pop_ok) begin
          slot_valid[pop_idx] <= 1'b0;
          playing             <= 1'b1;
          expected_sequence   <= pop_seq + apjb_pkg::SEQ_W'(1);
        end
      end

      // output register
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          apjb_pkg::CFG_INITIAL_THRESHOLD: begin
            cfg.initial_threshold <= cfg_data[apjb_pkg::THR_W-1:0];
            live_threshold        <= cfg_data[apjb_pkg::THR_W-1:0];
          end
          apjb_pkg::CFG_MIN_THRESHOLD: begin
            cfg.min_threshold <= cfg_data[apjb_pkg::THR_W-1:0];
          end
          apjb_pkg::CFG_MAX_THRESHOLD: begin
            cfg.max_threshold <= cfg_data[apjb_pkg::THR_W-1:0];
          end
          apjb_pkg::CFG_ADAPTIVE_ENABLE: begin
            cfg.adaptive_enable <= cfg_data[0];
          end
          apjb_pkg::CFG_POPS_PER_ADAPT: begin
            cfg.pops_per_adapt <= cfg_data[apjb_pkg::PPA_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // transaction and result payload registers
  always_ff @(posedge clk) begin
    if (scan_start) begin
      kind_q   <= req.kind;
      seq_q    <= req.sequence_req;
      pay_q    <= PAYLOAD_BITS'(req.payload);
      jitter_q <= req.jitter_est;
    end
    if (finish) begin
      rsp.ok            <= (kind_q == apjb_pkg::KIND_PUSH) ? push_ok : pop_ok;
      rsp.out_sequence  <= pop_ok ? pop_seq : '0;
      rsp.out_payload   <= pop_ok ? apjb_pkg::HANDLE_W'(pop_pay) : '0;
      rsp.threshold_now <= live_threshold_next;
      rsp.occupancy     <= apjb_pkg::OCC_W'(count_next);
    end
  end

  // stored count tracks the valid bits
  `APJB_ASSERT_ALWAYS(count_matches_valid, clk, rst, 32'(count) == $countones(slot_valid), "occupancy count disagrees with valid bits")
  // a push that is stored always found a free slot during the sweep
  `APJB_ASSERT_IMP(store_has_free_slot, clk, rst, (state == ST_FINISH) && push_store, scan_st.free, "push stored without a free slot")
  // outside configuration writes the threshold moves by at most one step
  `APJB_ASSERT_NXT(threshold_single_step, clk, rst, !cfg_we, (live_threshold == $past(live_threshold)) || (live_threshold == $past(live_threshold) + 7'd1) || (live_threshold == $past(live_threshold) - 7'd1), "threshold moved by more than one step")

endmodule
